// ===== rtl/bcdh_pkg.sv =====
// shared types and constants for the brake chopper duty hysteresis block
package bcdh_pkg;

   localparam int VoltW      = 16;
   localparam int DutyW      = 7;
   localparam int CsrAddrW   = 2;
   localparam int CsrDataW   = 16;
   localparam int DivSteps   = DutyW;
   localparam int DivCntW    = $clog2(DivSteps);

   localparam logic [VoltW-1:0]   LimMax      = 16'hFFFF;
   localparam logic [VoltW:0]     StopMargin  = 17'd90;
   localparam logic [VoltW:0]     StartMargin = 17'd110;
   localparam logic [DutyW-1:0]   FullDuty    = 7'd100;
   localparam logic [DutyW-1:0]   HalfDuty    = 7'd50;

   localparam logic [CsrAddrW-1:0] CsrDutyPercent  = 2'd0;
   localparam logic [CsrAddrW-1:0] CsrOvervoltPt   = 2'd1;
   localparam logic [CsrAddrW-1:0] CsrOvervoltScl  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIV    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef struct packed {
      logic start;     // latch sample, load divider
      logic div_step;  // one quotient bit
      logic finish;    // update chopper state and load result
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// ===== rtl/bcdh_ctrl.sv =====
// controller state machine: sequences divider, state update and result handoff
module bcdh_ctrl import bcdh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to be free
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/bcdh_datapath.sv =====
// datapath: config registers, duty divider, limit product and chopper state
module bcdh_datapath import bcdh_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic [VoltW-1:0]    bus_volts,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                brake_on
);

   logic [DutyW-1:0]   duty_ff;
   logic [VoltW-1:0]   point_ff, scale_ff;
   logic [VoltW-1:0]   volts_ff;
   logic [2*VoltW-1:0] prod_ff;
   logic [DutyW-1:0]   dq_ff, dq_in;
   logic [DutyW-1:0]   rem_ff, rem_in;
   logic [DutyW-1:0]   den_ff;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               chop_ff, chop_in;
   logic               phase_ff, phase_in;
   logic [VoltW-1:0]   ticks_ff, ticks_in;
   logic               brake_ff;

   logic [DutyW-1:0]   duty;
   logic               duty_zero, duty_full, duty_low;
   logic [DutyW:0]     trial;
   logic               qbit;
   logic [VoltW-1:0]   lim, on_cnt, off_cnt, ticks_inc;
   logic [VoltW:0]     stop_lvl, start_lvl;

   assign duty      = (duty_ff > FullDuty) ? FullDuty : duty_ff;
   assign duty_zero = (duty == '0);
   assign duty_full = (duty == FullDuty);
   assign duty_low  = (duty <= HalfDuty);

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff  <= '0;
         point_ff <= '0;
         scale_ff <= VoltW'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CsrDutyPercent: duty_ff  <= csr_wdata[DutyW-1:0];
            CsrOvervoltPt:  point_ff <= csr_wdata[VoltW-1:0];
            CsrOvervoltScl: scale_ff <= csr_wdata[VoltW-1:0];
            default: ;
         endcase
      end
   end

   // restoring divider, one quotient bit per step
   assign trial = {rem_ff, dq_ff[DutyW-1]};
   assign qbit  = (trial >= {1'b0, den_ff});

   always_comb begin
      dq_in  = dq_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.start) begin
         dq_in  = duty_low ? (FullDuty - duty) : duty;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in = qbit ? DutyW'(trial - {1'b0, den_ff}) : trial[DutyW-1:0];
         dq_in  = {dq_ff[DutyW-2:0], qbit};
         cnt_in = cnt_ff + DivCntW'(1);
      end
   end

   assign status.div_last = (cnt_ff == DivCntW'(DivSteps - 1));

   always_ff @(posedge clock) begin
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      prod_ff <= point_ff * scale_ff;
      if (cmd.start) begin
         volts_ff <= bus_volts;
         den_ff   <= duty_low ? duty : (FullDuty - duty);
      end
   end

   // phase lengths and limit thresholds, sums kept at 17 bits
   assign on_cnt    = duty_full ? LimMax : (duty_low ? VoltW'(1) : VoltW'(dq_ff));
   assign off_cnt   = duty_full ? '0 : (duty_low ? VoltW'(dq_ff) : VoltW'(1));
   assign lim       = (prod_ff > (2*VoltW)'(LimMax)) ? LimMax : prod_ff[VoltW-1:0];
   assign stop_lvl  = {1'b0, lim} + StopMargin;
   assign start_lvl = {1'b0, lim} + StartMargin;
   assign ticks_inc = ticks_ff + VoltW'(1);

   always_comb begin
      chop_in  = chop_ff;
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      if (!duty_zero) begin
         if ({1'b0, volts_ff} < stop_lvl) begin
            chop_in  = 1'b0;
            phase_in = 1'b0;
            ticks_in = '0;
         end else if (!chop_ff) begin
            if ({1'b0, volts_ff} > start_lvl) begin
               chop_in  = 1'b1;
               phase_in = 1'b1;
               ticks_in = '0;
            end
         end else begin
            ticks_in = ticks_inc;
            if (!phase_ff) begin
               if (ticks_inc > off_cnt) begin
                  phase_in = 1'b1;
                  ticks_in = '0;
               end
            end else if (ticks_inc > on_cnt) begin
               phase_in = 1'b0;
               ticks_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chop_ff  <= 1'b0;
         phase_ff <= 1'b0;
         ticks_ff <= '0;
      end else if (cmd.finish) begin
         chop_ff  <= chop_in;
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) brake_ff <= duty_zero ? 1'b0 : phase_in;
   end

   assign brake_on = brake_ff;

endmodule

// ===== rtl/brake_chopper_duty_hysteresis_top.sv =====
// Brake chopper with bus voltage hysteresis and a fixed duty on/off pattern.
// One req transfer carries one DC bus voltage sample; each sample gives
// exactly one rsp transfer whose bit says whether the brake resistor is on.
// The csr port writes duty_percent (0), overvolt_point (1) and
// overvolt_scale (2) at any edge with csr_we high; write only while idle.
// Sequence: the sample is latched at its req transfer, then the bit-serial
// duty divider produces the quotient, and then the chopper state is updated
// as the result is loaded. The limit product is registered alongside the
// divider. A new sample is not taken until the previous one is finished.
// The next sample is taken as soon as the state machine is back in idle,
// even while the previous result still waits in the output register.
// If the receiver stalls, the finished item waits until the output register
// is free; nothing is dropped.
// Synchronous active-high reset clears the chopper state, the registers to
// their defaults (scale 1, others 0) and any pending result.
module brake_chopper_duty_hysteresis_top import bcdh_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] bus_volts
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [0] brake_on, [7:1] zero
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       brake_on;

   bcdh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bcdh_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .bus_volts (req_tdata[VoltW-1:0]),
      .cmd       (cmd),
      .status    (status),
      .brake_on  (brake_on)
   );

   assign rsp_tdata = {7'b0, brake_on};

endmodule
